### rtl/psg_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package psg_pkg;

  // Fixed field widths of the request and result channels.
  localparam int SIZE_W = 5;
  localparam int POS_W  = 4;
  localparam int VAL_W  = 16;

  // Request function codes.
  localparam logic FUNC_LOAD = 1'b0;
  localparam logic FUNC_STEP = 1'b1;

  // Commands broadcast from the controller to every cell of the row.
  typedef struct packed {
    logic load;     // write the addressed cell
    logic swap;     // apply the swap and the direction flips
    logic capture;  // copy the arrangement into the output shift row
    logic shift;    // move the output shift row one cell toward slot 0
  } cell_cmd_t;

endpackage

`default_nettype wire

### rtl/psg_if.sv
`timescale 1ns / 1ps
`default_nettype none

// Request channel: one load or step request.
interface psg_req_if;
  logic                       valid;
  logic                       ready;
  logic                       func;
  logic [psg_pkg::POS_W-1:0]  position;
  logic [psg_pkg::VAL_W-1:0]  value;

  modport source (output valid, func, position, value, input ready);
  modport sink   (input valid, func, position, value, output ready);
endinterface

// Result channel: one emitted element or the done marker.
interface psg_res_if;
  logic                       valid;
  logic                       ready;
  logic                       element_valid;
  logic [psg_pkg::VAL_W-1:0]  element_value;
  logic [psg_pkg::POS_W-1:0]  element_position;
  logic                       last;
  logic                       done_res;

  modport source (output valid, element_valid, element_value, element_position, last,
                  done_res, input ready);
  modport sink   (input valid, element_valid, element_value, element_position, last,
                  done_res, output ready);
endinterface

`default_nettype wire

### rtl/psg_cell.sv
`timescale 1ns / 1ps
`default_nettype none

// One slot of the permutation row. It holds a value and its direction, takes
// part in the search wave for the largest mobile value, applies the swap and
// flip, and holds one stage of the output shift row.
module psg_cell #(
  parameter int VALUE_BITS = 16,
  parameter int IDX_W      = 4,
  parameter int INDEX      = 0
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire psg_pkg::cell_cmd_t    cmd_i,
  input  wire logic                  active_i,
  input  wire logic                  right_active_i,
  input  wire logic [IDX_W-1:0]      load_pos_i,
  input  wire logic [VALUE_BITS-1:0] load_val_i,
  input  wire logic [VALUE_BITS-1:0] left_val_i,
  input  wire logic                  left_dir_i,
  input  wire logic [VALUE_BITS-1:0] right_val_i,
  input  wire logic                  right_dir_i,
  output logic      [VALUE_BITS-1:0] val_o,
  output logic                       dir_o,
  input  wire logic [VALUE_BITS-1:0] best_val_i,
  input  wire logic [IDX_W-1:0]      best_idx_i,
  input  wire logic                  best_dir_i,
  output logic      [VALUE_BITS-1:0] best_val_o,
  output logic      [IDX_W-1:0]      best_idx_o,
  output logic                       best_dir_o,
  input  wire logic [VALUE_BITS-1:0] mob_val_i,
  input  wire logic [IDX_W-1:0]      mob_idx_i,
  input  wire logic                  mob_dir_i,
  input  wire logic [VALUE_BITS-1:0] shadow_i,
  output logic      [VALUE_BITS-1:0] shadow_o
);

  localparam logic [IDX_W:0]   SELF     = (IDX_W+1)'(INDEX);
  localparam logic [IDX_W:0]   SELF_P1  = (IDX_W+1)'(INDEX + 1);
  localparam logic [IDX_W-1:0] SELF_IDX = IDX_W'(INDEX);
  localparam logic             HAS_LEFT = (INDEX != 0);

  logic [VALUE_BITS-1:0] val_q, val_d;
  logic                  dir_q, dir_d;
  logic [VALUE_BITS-1:0] shadow_q, shadow_d;
  logic [VALUE_BITS-1:0] best_val_q, best_val_d;
  logic [IDX_W-1:0]      best_idx_q, best_idx_d;
  logic                  best_dir_q, best_dir_d;

  logic [VALUE_BITS-1:0] nb_val;
  logic                  nb_ok;
  logic                  is_mobile;
  logic                  take_best;
  logic [IDX_W:0]        mob_ext;
  logic [IDX_W:0]        mob_p1;
  logic                  take_right;
  logic                  take_left;
  logic [VALUE_BITS-1:0] swp_val;
  logic                  swp_dir;

  // Search wave: keep the incoming best unless this slot is mobile and larger.
  // Strict compare keeps the lowest slot among equal candidates.
  always_comb begin
    nb_val     = dir_q ? right_val_i : left_val_i;
    nb_ok      = dir_q ? right_active_i : HAS_LEFT;
    is_mobile  = active_i && nb_ok && (val_q > nb_val);
    take_best  = is_mobile && (val_q > best_val_i);
    best_val_d = take_best ? val_q    : best_val_i;
    best_idx_d = take_best ? SELF_IDX : best_idx_i;
    best_dir_d = take_best ? dir_q    : best_dir_i;
  end

  // Swap partner selection: the mobile slot takes its target neighbor and the
  // target takes the mobile slot, each with its direction.
  always_comb begin
    mob_ext    = {1'b0, mob_idx_i};
    mob_p1     = mob_ext + (IDX_W+1)'(1);
    take_right = mob_dir_i ? (mob_ext == SELF) : (mob_ext == SELF_P1);
    take_left  = mob_dir_i ? (mob_p1 == SELF)  : (mob_ext == SELF);
    swp_val    = val_q;
    swp_dir    = dir_q;
    if (take_right) begin
      swp_val = right_val_i;
      swp_dir = right_dir_i;
    end else if (take_left) begin
      swp_val = left_val_i;
      swp_dir = left_dir_i;
    end
  end

  // Next slot contents for a load or a step.
  always_comb begin
    val_d = val_q;
    dir_d = dir_q;
    if (cmd_i.load && (load_pos_i == SELF_IDX)) begin
      val_d = load_val_i;
      dir_d = 1'b0;
    end else if (cmd_i.swap) begin
      val_d = swp_val;
      dir_d = swp_dir ^ (active_i && (swp_val > mob_val_i));
    end
  end

  // Output shift row: capture the arrangement, then move toward slot 0.
  always_comb begin
    shadow_d = shadow_q;
    if (cmd_i.capture) begin
      shadow_d = val_q;
    end else if (cmd_i.shift) begin
      shadow_d = shadow_i;
    end
  end

  // Direction and search registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dir_q      <= 1'b0;
      best_val_q <= '0;
      best_idx_q <= '0;
      best_dir_q <= 1'b0;
    end else begin
      dir_q      <= dir_d;
      best_val_q <= best_val_d;
      best_idx_q <= best_idx_d;
      best_dir_q <= best_dir_d;
    end
  end

  // Value storage, no reset.
  always_ff @(posedge clk_i) begin
    val_q    <= val_d;
    shadow_q <= shadow_d;
  end

  assign val_o      = val_q;
  assign dir_o      = dir_q;
  assign best_val_o = best_val_q;
  assign best_idx_o = best_idx_q;
  assign best_dir_o = best_dir_q;
  assign shadow_o   = shadow_q;

endmodule

`default_nettype wire

### rtl/permutation_step_generator_top.sv
`timescale 1ns / 1ps
`default_nettype none
// A load request is taken whenever the controller is idle and produces no result.
// A step request emits n elements (n = size in use), or only the done marker once finished;
// back-pressure can stall the emission. After a load, a swap or a size write a search wave
// crosses all MAX_ELEMENTS cells, so the next step request waits until it has settled; loads
// go back to back while idle. Reset clears directions, the finished flag and the output, sets
// the size to 1, and starts a search wave; values stay undefined until loaded.
module permutation_step_generator_top #(
  parameter int MAX_ELEMENTS = 16,
  parameter int VALUE_BITS   = 16
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       cfg_we_i,
  input  wire logic [psg_pkg::SIZE_W-1:0] cfg_wdata_i,
  psg_req_if.sink                         req_i,
  psg_res_if.source                       res_o
);

  localparam int IDX_W  = (MAX_ELEMENTS > 1) ? $clog2(MAX_ELEMENTS) : 1;
  localparam int CNT_W  = $clog2(MAX_ELEMENTS + 1);
  localparam int CMP_W  = (CNT_W > psg_pkg::POS_W) ? CNT_W : psg_pkg::POS_W;
  localparam int SZ_W   = (CNT_W > psg_pkg::SIZE_W) ? CNT_W : psg_pkg::SIZE_W;
  localparam int VCOPY  = (VALUE_BITS < psg_pkg::VAL_W) ? VALUE_BITS : psg_pkg::VAL_W;
  localparam int PCOPY  = (IDX_W < psg_pkg::POS_W) ? IDX_W : psg_pkg::POS_W;
  localparam logic [CNT_W-1:0] SETTLE_MAX = CNT_W'(MAX_ELEMENTS);

  typedef enum logic {
    S_IDLE,
    S_EMIT
  } state_e;

  state_e                      state_q;
  logic [CNT_W-1:0]            n_q;
  logic [CNT_W-1:0]            settle_q;
  logic [IDX_W-1:0]            cnt_q;
  logic                        fin_mode_q;
  logic                        found_q;
  logic                        finished_q;
  logic                        out_valid_q;
  logic                        out_ev_q;
  logic [psg_pkg::VAL_W-1:0]   out_val_q;
  logic [psg_pkg::POS_W-1:0]   out_pos_q;
  logic                        out_last_q;
  logic                        out_done_q;

  psg_pkg::cell_cmd_t          cmd;
  logic                        settled;
  logic                        out_free;
  logic                        acc;
  logic                        is_load;
  logic                        is_step;
  logic                        load_hit;
  logic                        emit;
  logic                        cnt_last;
  logic                        found;
  logic [IDX_W-1:0]            load_idx;
  logic [VALUE_BITS-1:0]       load_val;
  logic [psg_pkg::VAL_W-1:0]   elem_val;
  logic [psg_pkg::POS_W-1:0]   elem_pos;
  logic [SZ_W-1:0]             size_ext;
  logic [SZ_W-1:0]             n_eff_w;
  logic [CNT_W-1:0]            n_eff;

  logic [MAX_ELEMENTS-1:0]     active_w;
  logic [MAX_ELEMENTS-1:0]     dir_w;
  logic [VALUE_BITS-1:0]       val_w      [MAX_ELEMENTS];
  logic [VALUE_BITS-1:0]       best_val_w [MAX_ELEMENTS];
  logic [IDX_W-1:0]            best_idx_w [MAX_ELEMENTS];
  logic [MAX_ELEMENTS-1:0]     best_dir_w;
  logic [VALUE_BITS-1:0]       shadow_w   [MAX_ELEMENTS];

  logic [VALUE_BITS-1:0]       mob_val;
  logic [IDX_W-1:0]            mob_idx;
  logic                        mob_dir;

  // The search result is final at the last cell of the row.
  assign mob_val = best_val_w[MAX_ELEMENTS-1];
  assign mob_idx = best_idx_w[MAX_ELEMENTS-1];
  assign mob_dir = best_dir_w[MAX_ELEMENTS-1];
  assign found   = (mob_val != '0);

  // Row of cells with neighbor links, the search chain and the output shift row.
  for (genvar i = 0; i < MAX_ELEMENTS; i++) begin : gen_cell
    logic [VALUE_BITS-1:0] left_val;
    logic                  left_dir;
    logic [VALUE_BITS-1:0] right_val;
    logic                  right_dir;
    logic                  right_act;
    logic [VALUE_BITS-1:0] bin_val;
    logic [IDX_W-1:0]      bin_idx;
    logic                  bin_dir;
    logic [VALUE_BITS-1:0] sh_in;

    assign active_w[i] = (CNT_W'(i) < n_q);

    if (i == 0) begin : gen_first
      assign left_val = '0;
      assign left_dir = 1'b0;
      assign bin_val  = '0;
      assign bin_idx  = '0;
      assign bin_dir  = 1'b0;
    end else begin : gen_inner_left
      assign left_val = val_w[i-1];
      assign left_dir = dir_w[i-1];
      assign bin_val  = best_val_w[i-1];
      assign bin_idx  = best_idx_w[i-1];
      assign bin_dir  = best_dir_w[i-1];
    end

    if (i == MAX_ELEMENTS - 1) begin : gen_last
      assign right_val = '0;
      assign right_dir = 1'b0;
      assign right_act = 1'b0;
      assign sh_in     = '0;
    end else begin : gen_inner_right
      assign right_val = val_w[i+1];
      assign right_dir = dir_w[i+1];
      assign right_act = active_w[i+1];
      assign sh_in     = shadow_w[i+1];
    end

    psg_cell #(
      .VALUE_BITS (VALUE_BITS),
      .IDX_W      (IDX_W),
      .INDEX      (i)
    ) u_cell (
      .clk_i          (clk_i),
      .rst_ni         (rst_ni),
      .cmd_i          (cmd),
      .active_i       (active_w[i]),
      .right_active_i (right_act),
      .load_pos_i     (load_idx),
      .load_val_i     (load_val),
      .left_val_i     (left_val),
      .left_dir_i     (left_dir),
      .right_val_i    (right_val),
      .right_dir_i    (right_dir),
      .val_o          (val_w[i]),
      .dir_o          (dir_w[i]),
      .best_val_i     (bin_val),
      .best_idx_i     (bin_idx),
      .best_dir_i     (bin_dir),
      .best_val_o     (best_val_w[i]),
      .best_idx_o     (best_idx_w[i]),
      .best_dir_o     (best_dir_w[i]),
      .mob_val_i      (mob_val),
      .mob_idx_i      (mob_idx),
      .mob_dir_i      (mob_dir),
      .shadow_i       (sh_in),
      .shadow_o       (shadow_w[i])
    );
  end

  // Effective size from a configuration write: zero counts as one, clamp at the row length.
  always_comb begin
    size_ext = SZ_W'(cfg_wdata_i);
    if (size_ext == '0) begin
      n_eff_w = SZ_W'(1);
    end else if (size_ext > SZ_W'(MAX_ELEMENTS)) begin
      n_eff_w = SZ_W'(MAX_ELEMENTS);
    end else begin
      n_eff_w = size_ext;
    end
    n_eff = CNT_W'(n_eff_w);
  end

  // Width adaption of request and result fields.
  always_comb begin
    load_val              = '0;
    load_val[VCOPY-1:0]   = req_i.value[VCOPY-1:0];
    load_idx              = '0;
    load_idx[PCOPY-1:0]   = req_i.position[PCOPY-1:0];
    elem_val              = '0;
    elem_val[VCOPY-1:0]   = shadow_w[0][VCOPY-1:0];
    elem_pos              = '0;
    elem_pos[PCOPY-1:0]   = cnt_q[PCOPY-1:0];
  end

  // Handshake and row commands.
  always_comb begin
    settled     = (settle_q == '0);
    out_free    = !out_valid_q || res_o.ready;
    is_load     = (req_i.func == psg_pkg::FUNC_LOAD);
    is_step     = (req_i.func == psg_pkg::FUNC_STEP);
    req_i.ready = (state_q == S_IDLE) && (is_load || settled);
    acc         = req_i.valid && req_i.ready;
    load_hit    = (CMP_W'(req_i.position) < CMP_W'(n_q));
    emit        = (state_q == S_EMIT) && out_free;
    cnt_last    = ((CNT_W'(cnt_q) + CNT_W'(1)) == n_q);
    cmd.load    = acc && is_load && load_hit;
    cmd.capture = acc && is_step && !finished_q;
    cmd.swap    = cmd.capture && found;
    cmd.shift   = emit && !fin_mode_q;
  end

  // Controller state, settle counter and the registered result.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      n_q         <= CNT_W'(1);
      settle_q    <= SETTLE_MAX;
      cnt_q       <= '0;
      fin_mode_q  <= 1'b0;
      found_q     <= 1'b0;
      finished_q  <= 1'b0;
      out_valid_q <= 1'b0;
      out_ev_q    <= 1'b0;
      out_val_q   <= '0;
      out_pos_q   <= '0;
      out_last_q  <= 1'b0;
      out_done_q  <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        n_q <= n_eff;
      end

      // Any change of the row or the size restarts the search wave.
      if (cfg_we_i || cmd.load || cmd.swap) begin
        settle_q <= SETTLE_MAX;
      end else if (!settled) begin
        settle_q <= settle_q - CNT_W'(1);
      end

      if (out_valid_q && res_o.ready) begin
        out_valid_q <= 1'b0;
      end

      unique case (state_q)
        S_IDLE: begin
          if (cmd.load) begin
            finished_q <= 1'b0;
          end
          if (acc && is_step) begin
            state_q    <= S_EMIT;
            cnt_q      <= '0;
            fin_mode_q <= finished_q;
            found_q    <= !finished_q && found;
            if (!finished_q && !found) begin
              finished_q <= 1'b1;
            end
          end
        end
        S_EMIT: begin
          if (out_free) begin
            out_valid_q <= 1'b1;
            if (fin_mode_q) begin
              out_ev_q   <= 1'b0;
              out_val_q  <= '0;
              out_pos_q  <= '0;
              out_last_q <= 1'b1;
              out_done_q <= 1'b1;
              state_q    <= S_IDLE;
            end else begin
              out_ev_q   <= 1'b1;
              out_val_q  <= elem_val;
              out_pos_q  <= elem_pos;
              out_last_q <= cnt_last;
              out_done_q <= !found_q;
              cnt_q      <= cnt_q + IDX_W'(1);
              if (cnt_last) begin
                state_q <= S_IDLE;
              end
            end
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign res_o.valid            = out_valid_q;
  assign res_o.element_valid    = out_ev_q;
  assign res_o.element_value    = out_val_q;
  assign res_o.element_position = out_pos_q;
  assign res_o.last             = out_last_q;
  assign res_o.done_res         = out_done_q;

  // The row must not change while an arrangement is being emitted.
  a_row_stable_in_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_EMIT) |-> (!cmd.load && !cmd.swap))
    else $error("row written during emission");

  // A swap only uses a real mobile value inside the size in use.
  a_swap_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.swap |-> ((mob_val != '0) && (CNT_W'(mob_idx) < n_q)))
    else $error("swap with invalid mobile value");

  // Emitting the final arrangement or the done marker implies the finished flag.
  a_done_sets_finished: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == S_EMIT) && !found_q) |-> finished_q)
    else $error("final arrangement without finished flag");

  // The emit counter stays inside the size in use.
  a_cnt_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == S_EMIT) && !fin_mode_q) |-> (CNT_W'(cnt_q) < n_q))
    else $error("emit position beyond size");

endmodule

`default_nettype wire

### bench/permutation_step_generator_top_tb.sv
`timescale 1ns / 1ps

module permutation_step_generator_top_tb;

  localparam int ROW_MAX       = 16;
  localparam int SETTLE_CYCLES = 2 * ROW_MAX + 8;
  localparam int IDLE_PCT      = 36;
  localparam int RANDOM_ITEMS  = 200;
  localparam int STEP_CAP      = 30;
  localparam int PRINT_CAP     = 40;

  // Direction of each element in the row.
  typedef enum bit {
    HEAD_LEFT  = 1'b0,
    HEAD_RIGHT = 1'b1
  } heading_e;

  // One emitted element, or the done marker.
  typedef struct packed {
    logic                      present;
    logic [psg_pkg::VAL_W-1:0] value;
    logic [psg_pkg::POS_W-1:0] slot;
    logic                      last;
    logic                      done;
  } elem_t;

  // Tracks the row, predicts the elements of each step and checks them in order.
  class perm_tracker;
    logic [psg_pkg::VAL_W-1:0]  vals [ROW_MAX];
    heading_e                   heads [ROW_MAX];
    bit                         fin;
    logic [psg_pkg::SIZE_W-1:0] size_reg;
    elem_t                      pending[$];
    int                         errors;
    int                         checked;

    function new();
      for (int i = 0; i < ROW_MAX; i++) begin
        vals[i]  = '0;
        heads[i] = HEAD_LEFT;
      end
      fin      = 1'b0;
      size_reg = 5'd1;
      errors   = 0;
      checked  = 0;
    endfunction

    function void set_size(input logic [psg_pkg::SIZE_W-1:0] s);
      size_reg = s;
    endfunction

    // A size of zero counts as one; sizes above the row count as the full row.
    function int live_count();
      if (size_reg == 0) return 1;
      if (size_reg > ROW_MAX) return ROW_MAX;
      return int'(size_reg);
    endfunction

    // Applies one accepted request; returns 0 for a load that the block ignores.
    function bit note_request(input logic f, input logic [psg_pkg::POS_W-1:0] p,
                              input logic [psg_pkg::VAL_W-1:0] v);
      int                        n;
      int                        best_idx;
      int                        other;
      logic [psg_pkg::VAL_W-1:0] best;
      logic [psg_pkg::VAL_W-1:0] tv;
      heading_e                  th;
      bit                        found;
      bit                        mobile;
      elem_t                     e;

      n = live_count();
      if (f == psg_pkg::FUNC_LOAD) begin
        if (int'(p) >= n) return 1'b0;
        vals[p]  = v;
        heads[p] = HEAD_LEFT;
        fin      = 1'b0;
        return 1'b1;
      end

      if (fin) begin
        e = '{present: 1'b0, value: '0, slot: '0, last: 1'b1, done: 1'b1};
        pending.push_back(e);
        return 1'b1;
      end

      // Largest mobile value; the lowest slot wins a tie.
      best     = '0;
      best_idx = 0;
      found    = 1'b0;
      for (int i = 0; i < n; i++) begin
        if (heads[i] == HEAD_LEFT) mobile = (i != 0) && (vals[i] > vals[i - 1]);
        else mobile = (i + 1 < n) && (vals[i] > vals[i + 1]);
        if (mobile && vals[i] > best) begin
          best     = vals[i];
          best_idx = i;
          found    = 1'b1;
        end
      end

      for (int i = 0; i < n; i++) begin
        e.present = 1'b1;
        e.value   = vals[i];
        e.slot    = psg_pkg::POS_W'(i);
        e.last    = (i + 1 == n);
        e.done    = !found;
        pending.push_back(e);
      end

      if (!found) begin
        fin = 1'b1;
        return 1'b1;
      end

      // Swap the mobile value with its neighbor, then flip every larger value.
      other           = (heads[best_idx] == HEAD_LEFT) ? best_idx - 1 : best_idx + 1;
      tv              = vals[best_idx];
      th              = heads[best_idx];
      vals[best_idx]  = vals[other];
      heads[best_idx] = heads[other];
      vals[other]     = tv;
      heads[other]    = th;
      for (int i = 0; i < n; i++) begin
        if (vals[i] > best) heads[i] = (heads[i] == HEAD_LEFT) ? HEAD_RIGHT : HEAD_LEFT;
      end
      return 1'b1;
    endfunction

    task report(input string msg);
      if (errors < PRINT_CAP) $display("MISMATCH at %0t: %s", $time, msg);
      errors++;
    endtask

    task check_element(input elem_t got);
      elem_t want;
      string bad;

      if (pending.size() == 0) begin
        report($sformatf("unexpected result valid=%0b value=%h pos=%0d last=%0b done=%0b",
                         got.present, got.value, got.slot, got.last, got.done));
        return;
      end
      want = pending.pop_front();
      bad  = "";
      if (got.present !== want.present) bad = {bad, " element_valid"};
      if (got.value !== want.value) bad = {bad, " element_value"};
      if (got.slot !== want.slot) bad = {bad, " element_position"};
      if (got.last !== want.last) bad = {bad, " last"};
      if (got.done !== want.done) bad = {bad, " done_res"};
      if (bad != "") begin
        report($sformatf("result %0d wrong in%s: got %0b/%h/%0d/%0b/%0b, want %0b/%h/%0d/%0b/%0b",
                         checked, bad, got.present, got.value, got.slot, got.last, got.done,
                         want.present, want.value, want.slot, want.last, want.done));
      end
      checked++;
    endtask
  endclass

  logic                       clk_i;
  logic                       rst_ni;
  logic                       cfg_we;
  logic [psg_pkg::SIZE_W-1:0] cfg_wdata;
  bit                         steady;
  int                         counted_items;
  int                         step_count;
  int                         full_runs;

  psg_req_if req_bus ();
  psg_res_if res_bus ();

  perm_tracker tracker = new();

  permutation_step_generator_top uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we),
    .cfg_wdata_i(cfg_wdata),
    .req_i      (req_bus),
    .res_o      (res_bus)
  );

  // Free-running clock.
  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // Mostly random values, with the two extremes mixed in.
  function automatic logic [psg_pkg::VAL_W-1:0] pick_value();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return '1;
      default: return psg_pkg::VAL_W'($urandom_range(0, 65535));
    endcase
  endfunction

  // Offers one request, with random gaps, until the block takes it.
  task automatic send_req(input logic f, input logic [psg_pkg::POS_W-1:0] p,
                          input logic [psg_pkg::VAL_W-1:0] v);
    while (!steady && $urandom_range(0, 99) < IDLE_PCT) begin
      req_bus.valid <= 1'b0;
      @(posedge clk_i);
    end
    req_bus.valid    <= 1'b1;
    req_bus.func     <= f;
    req_bus.position <= p;
    req_bus.value    <= v;
    do @(posedge clk_i); while (!req_bus.ready);
    if (tracker.note_request(f, p, v)) counted_items++;
    if (f == psg_pkg::FUNC_STEP) step_count++;
  endtask

  task automatic send_step();
    send_req(psg_pkg::FUNC_STEP, psg_pkg::POS_W'($urandom_range(0, 15)),
             psg_pkg::VAL_W'($urandom_range(0, 65535)));
  endtask

  // Waits until every predicted element is back and the row has had time to settle.
  task automatic settle();
    req_bus.valid <= 1'b0;
    while (tracker.pending.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_size(input logic [psg_pkg::SIZE_W-1:0] s);
    settle();
    cfg_we    <= 1'b1;
    cfg_wdata <= s;
    @(posedge clk_i);
    tracker.set_size(s);
    cfg_we <= 1'b0;
  endtask

  // Result side: random back-pressure and in-order checking.
  initial begin
    elem_t got;
    res_bus.ready = 1'b0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && res_bus.valid && res_bus.ready) begin
        got.present = res_bus.element_valid;
        got.value   = res_bus.element_value;
        got.slot    = res_bus.element_position;
        got.last    = res_bus.last;
        got.done    = res_bus.done_res;
        tracker.check_element(got);
      end
      res_bus.ready <= steady ? 1'b1 : ($urandom_range(0, 99) >= IDLE_PCT);
    end
  end

  // Stimulus.
  initial begin
    logic [psg_pkg::VAL_W-1:0]  row [ROW_MAX];
    logic [psg_pkg::VAL_W-1:0]  tv;
    logic [psg_pkg::SIZE_W-1:0] sz;
    int                         n;
    int                         j;
    int                         steps;
    int                         phase;
    int                         base_items;

    rst_ni           = 1'b0;
    cfg_we           = 1'b0;
    cfg_wdata        = '0;
    req_bus.valid    = 1'b0;
    req_bus.func     = psg_pkg::FUNC_LOAD;
    req_bus.position = '0;
    req_bus.value    = '0;
    steady           = 1'b0;
    counted_items    = 0;
    step_count       = 0;
    full_runs        = 0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Fill the whole row first so that no step ever reads an unloaded slot.
    // Two equal mobile values sit in slots 1 and 3; slot 0 holds zero.
    write_size(5'd16);
    for (int i = 0; i < ROW_MAX; i++) begin
      case (i)
        0: tv = '0;
        1: tv = '1;
        2: tv = 16'h5555;
        3: tv = '1;
        default: tv = psg_pkg::VAL_W'($urandom_range(0, 65535));
      endcase
      send_req(psg_pkg::FUNC_LOAD, psg_pkg::POS_W'(i), tv);
    end
    send_step();
    send_step();

    // Size zero acts as one: final arrangement, finished marker, ignored load, reload.
    write_size(5'd0);
    send_step();
    send_step();
    send_req(psg_pkg::FUNC_LOAD, psg_pkg::POS_W'(9), pick_value());
    send_step();
    send_req(psg_pkg::FUNC_LOAD, '0, 16'h0003);
    send_step();

    // A size above the row counts as the full row.
    write_size(5'd31);
    send_step();

    // Random phases: mostly complete permutation runs on short rows.
    base_items = counted_items;
    phase      = 0;
    while (counted_items - base_items < RANDOM_ITEMS) begin
      case ($urandom_range(0, 9))
        0: sz = 5'd0;
        1: sz = 5'd1;
        2: sz = 5'd16;
        3: sz = 5'd17;
        4: sz = 5'd31;
        5: sz = 5'd5;
        default: sz = psg_pkg::SIZE_W'($urandom_range(2, 4));
      endcase
      write_size(sz);
      steady = (phase == 3 || phase == 4);
      n      = tracker.live_count();

      if (n > 5) begin
        // Long rows: a few loads and steps only.
        repeat ($urandom_range(1, 4))
          send_req(psg_pkg::FUNC_LOAD, psg_pkg::POS_W'($urandom_range(0, 15)), pick_value());
        repeat ($urandom_range(1, 3)) send_step();
      end else if ($urandom_range(0, 3) != 0) begin
        // Distinct values, ascending or shuffled, stepped until finished.
        tv = psg_pkg::VAL_W'($urandom_range(1, 3000));
        for (int i = 0; i < n; i++) begin
          row[i] = tv;
          tv     = tv + psg_pkg::VAL_W'($urandom_range(1, 3000));
        end
        if ($urandom_range(0, 1) == 1) begin
          for (int i = n - 1; i > 0; i--) begin
            j      = $urandom_range(0, i);
            tv     = row[i];
            row[i] = row[j];
            row[j] = tv;
          end
        end
        for (int i = 0; i < n; i++) send_req(psg_pkg::FUNC_LOAD, psg_pkg::POS_W'(i), row[i]);
        steps = 0;
        while (!tracker.fin && steps < STEP_CAP) begin
          if ($urandom_range(0, 19) == 0)
            send_req(psg_pkg::FUNC_LOAD, psg_pkg::POS_W'($urandom_range(0, 15)),
                     pick_value());
          send_step();
          steps++;
        end
        if (tracker.fin) full_runs++;
        send_step();
      end else begin
        // Noise: random loads and steps, many loads out of range.
        repeat (10) begin
          if ($urandom_range(0, 1) == 1) send_step();
          else send_req(psg_pkg::FUNC_LOAD, psg_pkg::POS_W'($urandom_range(0, 15)),
                        pick_value());
        end
      end
      steady = 1'b0;
      phase++;
    end

    settle();
    $display("Run covered %0d requests (%0d steps) over %0d random phases and %0d full runs.",
             counted_items, step_count, phase, full_runs);
    $display("Checked %0d element results with %0d mismatches.", tracker.checked,
             tracker.errors);
    if (tracker.errors == 0 && tracker.pending.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  // Watchdog for a hung handshake.
  initial begin
    #20_000_000;
    $display("Timeout with %0d results still expected.", tracker.pending.size());
    $display("FAILED: results differ");
    $finish;
  end

endmodule
